// ----- design/cbeq_pkg.sv -----
package cbeq_pkg;

  // Opcodes of an input transaction
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_COEF   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Coefficient slots within one band
  localparam logic [2:0] SEL_B0 = 3'd0;
  localparam logic [2:0] SEL_B1 = 3'd1;
  localparam logic [2:0] SEL_B2 = 3'd2;
  localparam logic [2:0] SEL_A1 = 3'd3;
  localparam logic [2:0] SEL_A2 = 3'd4;

  localparam int COEFS_PER_BAND = 5;

  // Configuration register indexes
  localparam logic [1:0] CFG_BYPASS   = 2'd0;
  localparam logic [1:0] CFG_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_BANDS    = 2'd2;

  // Datapath widths
  localparam int COEF_W = 32;
  localparam int HIST_W = 32;
  localparam int PROD_W = COEF_W + HIST_W;
  localparam int ACC_W  = PROD_W + 3;

  // One history row: the four delay taps of one band of one channel
  typedef struct packed {
    logic signed [HIST_W-1:0] x1;
    logic signed [HIST_W-1:0] x2;
    logic signed [HIST_W-1:0] y1;
    logic signed [HIST_W-1:0] y2;
  } hist_row_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

// ----- design/cascaded_biquad_equalizer.sv -----
// Multichannel cascade of direct-form-I biquads sharing one 32x32 multiplier. A sample
// transaction (opcode 0) on a filtered channel runs through the first band_count sections:
// each band fetches its history row and five coefficients from two memories with
// registered reads, does five multiply-accumulates, then rounds, saturates and writes
// back. A fetch step comes before the first band, and the done state hands the result to
// the output register; only then is the next transaction accepted. A sample that is
// bypassed, on an inactive channel or given zero bands goes straight to the done state and
// from there to the output register. While the output register still holds an untaken
// result, a finished sample waits and the input stays stalled. Coefficient writes and
// history clears finish in the cycle they are accepted, and history is cleared through
// valid bits, so no clearing pass follows reset. A finished result waits in the output
// register while the next transaction is accepted.
module cascaded_biquad_equalizer
  import cbeq_pkg::*;
#(
  parameter int NUM_BANDS      = 8,
  parameter int NUM_CHANNELS   = 8,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [3:0]                    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [2:0]                    channel,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [2:0]                    coef_band,
  input  logic [2:0]                    coef_select,
  input  logic signed [COEF_W-1:0]      coef_value,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic [2:0]                    channel_out
);

  localparam int COEF_DEPTH = NUM_BANDS * COEFS_PER_BAND;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int HIST_DEPTH = NUM_BANDS * NUM_CHANNELS;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int BAND_W     = $clog2(NUM_BANDS + 1);

  localparam logic [2:0] STEP_FETCH = 3'd0;
  localparam logic [2:0] STEP_WB    = 3'd7;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << COEF_FRAC_BITS);
  localparam logic signed [ACC_W-1:0]  ROUND_HALF =
    ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0]  HIST_MAX = ACC_W'(32'h7FFF_FFFF);
  localparam logic signed [ACC_W-1:0]  HIST_MIN = -HIST_MAX - ACC_W'(1);
  localparam logic signed [HIST_W-1:0] SAMP_MAX =
    HIST_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [HIST_W-1:0] SAMP_MIN = -SAMP_MAX - HIST_W'(1);

  // configuration registers
  logic       bypass;
  logic [3:0] channels_in_use;
  logic [3:0] band_count;

  // control
  state_t state, state_next;
  logic [2:0]        step;
  logic [BAND_W-1:0] band;
  logic [BAND_W-1:0] band_next;
  logic [BAND_W-1:0] bands_eff;
  logic [BAND_W-1:0] bands_cfg;
  logic [4:0]        active_ch;
  logic              accept;
  logic              filter_it;
  logic              wb_step;
  logic              more_bands;
  logic              load_out;
  logic              hist_re;
  logic              coef_we;

  // datapath
  logic [2:0]                ch;
  logic signed [HIST_W-1:0]  xin;
  logic signed [SAMPLE_BITS-1:0] res;

  logic [BAND_W-1:0]         rd_band;
  logic [2:0]                rd_slot;
  logic [COEF_AW-1:0]        coef_raddr;
  logic [COEF_AW-1:0]        coef_waddr;
  logic [HIST_AW-1:0]        hist_raddr;
  logic [HIST_AW-1:0]        hist_waddr;

  logic [COEF_W-1:0]         coef_mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0]     coef_valid;
  logic [COEF_W-1:0]         coef_rd;
  logic                      coef_rd_ok;
  logic                      coef_rd_b0;
  logic signed [COEF_W-1:0]  coef_eff;

  hist_row_t                 hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0]     hist_valid;
  hist_row_t                 hist_rd;
  logic                      hist_rd_ok;
  hist_row_t                 hist_eff;
  hist_row_t                 hist_wr;

  logic [2:0]                mul_slot;
  logic signed [HIST_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      prod_valid;
  logic                      prod_first;
  logic                      prod_neg;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_base;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [HIST_W-1:0]  y_sec;
  logic signed [HIST_W-1:0]  y_out;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass          <= 1'b0;
      channels_in_use <= 4'd1;
      band_count      <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BYPASS:   bypass          <= cfg_data[0];
        CFG_CHANNELS: channels_in_use <= cfg_data;
        CFG_BANDS:    band_count      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp channel and band counts to what the block holds
  always_comb begin
    if (channels_in_use == 4'd0) begin
      active_ch = 5'd1;
    end else if (5'(channels_in_use) > 5'(NUM_CHANNELS)) begin
      active_ch = 5'(NUM_CHANNELS);
    end else begin
      active_ch = 5'(channels_in_use);
    end
    if (5'(band_count) > 5'(NUM_BANDS)) begin
      bands_cfg = BAND_W'(NUM_BANDS);
    end else begin
      bands_cfg = BAND_W'(band_count);
    end
  end

  assign accept     = in_valid && in_ready;
  assign filter_it  = !bypass && (5'(channel) < active_ch) && (bands_cfg != '0);
  assign wb_step    = (state == ST_RUN) && (step == STEP_WB);
  assign band_next  = band + BAND_W'(1);
  assign more_bands = band_next < bands_eff;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_SAMPLE) begin
          state_next = filter_it ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (wb_step && !more_bands) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    hist_re  = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_RUN:  hist_re  = (step == STEP_FETCH) || (step == STEP_WB && more_bands);
      ST_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Advance step and band counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
      band <= '0;
    end else if (state == ST_IDLE) begin
      step <= STEP_FETCH;
      band <= '0;
    end else if (state == ST_RUN) begin
      if (step == STEP_WB) begin
        step <= STEP_FETCH + 3'd1;
        band <= band_next;
      end else begin
        step <= step + 3'd1;
      end
    end
  end

  // Hold the transaction's channel, sample and band limit
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_SAMPLE) begin
      ch        <= channel;
      bands_eff <= bands_cfg;
      xin       <= HIST_W'(sample_in);
      res       <= sample_in;
    end else if (wb_step) begin
      xin <= y_sec;
      if (!more_bands) res <= SAMPLE_BITS'(y_out);
    end
  end

  // Read addresses: the next band is fetched during write back
  assign rd_band    = (step == STEP_WB) ? band_next : band;
  assign rd_slot    = (step == STEP_WB || step > SEL_A2) ? SEL_B0 : step;
  assign coef_raddr = COEF_AW'(rd_band * COEFS_PER_BAND + rd_slot);
  assign hist_raddr = HIST_AW'(rd_band * NUM_CHANNELS + ch);
  assign hist_waddr = HIST_AW'(band * NUM_CHANNELS + ch);
  assign coef_waddr = COEF_AW'(coef_band * COEFS_PER_BAND + coef_select);
  assign coef_we    = accept && opcode == OP_COEF &&
                      (5'(coef_band) < 5'(NUM_BANDS)) && (coef_select <= SEL_A2);

  // Coefficient memory
  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_waddr] <= coef_value;
    coef_rd    <= coef_mem[coef_raddr];
    coef_rd_b0 <= (rd_slot == SEL_B0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= '0;
      coef_rd_ok <= 1'b0;
    end else begin
      if (coef_we) coef_valid[coef_waddr] <= 1'b1;
      coef_rd_ok <= coef_valid[coef_raddr];
    end
  end

  // Unwritten coefficients read as unity b0, zero elsewhere
  always_comb begin
    if (coef_rd_ok)      coef_eff = coef_rd;
    else if (coef_rd_b0) coef_eff = COEF_ONE;
    else                 coef_eff = '0;
  end

  // History memory
  always_ff @(posedge clk) begin
    if (wb_step) hist_mem[hist_waddr] <= hist_wr;
    if (hist_re) hist_rd <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
      hist_rd_ok <= 1'b0;
    end else begin
      if (accept && opcode == OP_CLEAR) begin
        hist_valid <= '0;
      end else if (wb_step) begin
        hist_valid[hist_waddr] <= 1'b1;
      end
      if (hist_re) hist_rd_ok <= hist_valid[hist_raddr];
    end
  end

  assign hist_eff = hist_rd_ok ? hist_rd : '0;

  // Pick the multiplier operand for the coefficient that arrives this step
  assign mul_slot = step - 3'd1;

  always_comb begin
    case (mul_slot)
      SEL_B0:  mul_b = xin;
      SEL_B1:  mul_b = hist_eff.x1;
      SEL_B2:  mul_b = hist_eff.x2;
      SEL_A1:  mul_b = hist_eff.y1;
      default: mul_b = hist_eff.y2;
    endcase
  end

  // Multiply, registered
  always_ff @(posedge clk) begin
    prod       <= coef_eff * mul_b;
    prod_first <= (mul_slot == SEL_B0);
    prod_neg   <= (mul_slot == SEL_A1) || (mul_slot == SEL_A2);
  end

  always_ff @(posedge clk) begin
    if (rst) prod_valid <= 1'b0;
    else     prod_valid <= (state == ST_RUN) && (step != STEP_FETCH) && (step <= 3'd5);
  end

  // Accumulate: feed-forward terms add, feedback terms subtract
  assign acc_base = prod_first ? '0 : acc;
  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (prod_valid) acc <= prod_neg ? acc_base - prod_ext : acc_base + prod_ext;
  end

  // Round half up, saturate the section output and the final sample
  always_comb begin
    acc_rnd = acc + ROUND_HALF;
    acc_q   = acc_rnd >>> COEF_FRAC_BITS;
    if (acc_q > HIST_MAX)      y_sec = HIST_W'(HIST_MAX);
    else if (acc_q < HIST_MIN) y_sec = HIST_W'(HIST_MIN);
    else                       y_sec = HIST_W'(acc_q);
    if (y_sec > SAMP_MAX)      y_out = SAMP_MAX;
    else if (y_sec < SAMP_MIN) y_out = SAMP_MIN;
    else                       y_out = y_sec;
  end

  // Shift the delay taps of the band
  always_comb begin
    hist_wr.x1 = xin;
    hist_wr.x2 = hist_eff.x1;
    hist_wr.y1 = y_sec;
    hist_wr.y2 = hist_eff.y1;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_out  <= res;
      channel_out <= ch;
    end
  end

endmodule

// ----- design/cbeq_checker.sv -----
module cbeq_assertions
  import cbeq_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [1:0]                    opcode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic [2:0]                    channel_out
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(channel_out))
    else $error("result changed while stalled");

  // Drop a result only after it was taken
  a_out_taken: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without transaction");

  // Coefficient writes and clears finish at once
  a_ctrl_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode != OP_SAMPLE |=> in_ready)
    else $error("block busy after control transaction");

  // A sample keeps the block busy while it is filtered
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_SAMPLE |=> !in_ready)
    else $error("sample transaction accepted back to back");

  // Reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind cascaded_biquad_equalizer cbeq_assertions #(.SAMPLE_BITS(SAMPLE_BITS)) u_cbeq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .opcode      (opcode),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .sample_out  (sample_out),
  .channel_out (channel_out)
);
